// ===== rtl/core/tcsv_pkg.sv =====
// Shared constants, types and codes for the telemetry CSV field parser.
`default_nettype none

package tcsv_pkg;

  // Frame geometry
  localparam int FIELD_COUNT = 7;
  localparam int OUT_VALUES  = 7;
  localparam int VALUE_BITS  = 24;
  localparam int FN_W        = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
  localparam int OUT_W       = OUT_VALUES * VALUE_BITS;

  // Configuration register map
  localparam int APB_AW = 4;
  localparam logic [1:0] REG_HEADER    = 2'd0;
  localparam logic [1:0] REG_SEPARATOR = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  // Reset values of the configuration registers, window minimum and byte count ceiling
  localparam logic [7:0] HEADER_RST = 8'd65;
  localparam logic [7:0] SEP_RST    = 8'd44;
  localparam logic [7:0] WINDOW_RST = 8'd50;
  localparam logic [7:0] WINDOW_MIN = 8'd2;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // Number scan phase of the current field
  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,  // skipping leading whitespace
    PH_NUM  = 4'b0010,  // sign or digits taken
    PH_END  = 4'b0100,  // field ended, wait for separator
    PH_PAST = 4'b1000   // beyond the last field, wait for frame end
  } phase_e;

endpackage : tcsv_pkg

`default_nettype wire

// ===== rtl/core/telemetry_csv_field_parser_unit.sv =====
// Top level of the telemetry CSV field parser: byte stream in, parsed frames out.
//
// Usage: received bytes enter on the s_axis channel, one byte per transaction.
// Bytes are dropped until the header byte opens a frame; up to seven
// separator-delimited signed decimal fields are then read atoi-style and
// saturated to 24 bits. A frame leaves on the m_axis channel when the next
// header arrives (that header opens the next frame, tuser = 0) or when the
// frame reaches the window length in bytes (tuser = 1, back to hunting).
// The APB port sets the header byte, the separator byte and the window.
// An accepted byte is parsed from the input register; its frame, if any, is
// captured in the result register and shown on m_axis. Throughput: one byte
// per cycle unless the receiver stalls, set by the single parse step between
// the input register and the result register. On a stall the pending frame
// holds, at most one more byte enters the input register, and s_axis_tready
// then falls until the frame is taken. Reset clears the frame state and loads
// the default configuration (header 'A', separator ',', window 50).
`default_nettype none

module telemetry_csv_field_parser_unit
  import tcsv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Byte input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  // Frame output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [23:0] battery_raw, [47:24] temp_right,
                                            // [71:48] temp_left, [95:72] current_right,
                                            // [119:96] current_left, [143:120] speed_right,
                                            // [167:144] speed_left
  output logic              m_axis_tuser,   // [0] window_cut
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [7:0] header_q, sep_q, window_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RST;
      sep_q    <= SEP_RST;
      window_q <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HEADER:    header_q <= pwdata[7:0];
        REG_SEPARATOR: sep_q    <= pwdata[7:0];
        REG_WINDOW:    window_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER:    prdata = {24'd0, header_q};
      REG_SEPARATOR: prdata = {24'd0, sep_q};
      REG_WINDOW:    prdata = {24'd0, window_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       adv_ok, adv, s_fire;

  assign adv_ok        = !m_axis_tvalid || m_axis_tready;
  assign adv           = in_valid_q && adv_ok;
  assign s_axis_tready = !in_valid_q || adv_ok;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Frame state
  logic            in_frame_q, in_frame_d;
  logic [FN_W-1:0] field_num_q, field_num_d;
  logic [7:0]      frame_cnt_q, frame_cnt_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  value_t          vals_q    [FIELD_COUNT];
  value_t          vals_take [FIELD_COUNT];
  value_t          vals_d    [FIELD_COUNT];

  // Byte classification
  logic [7:0] c;
  logic       is_hdr, is_sep, is_digit, is_blank, is_sign;
  logic [7:0] window_eff, cnt_inc;
  logic       last_field;
  value_t     acc_in, acc_sum;
  logic       wr_digit;

  assign c          = in_byte_q;
  assign is_hdr     = (c == header_q);
  assign is_sep     = (c == sep_q);
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_blank   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_sign    = (c == CH_PLUS) || (c == CH_MINUS);
  assign window_eff = (window_q < WINDOW_MIN) ? WINDOW_MIN : window_q;
  assign cnt_inc    = (frame_cnt_q == COUNT_MAX) ? frame_cnt_q : frame_cnt_q + 8'd1;
  assign last_field = (({1'b0, field_num_q} + (FN_W+1)'(1)) >= (FN_W+1)'(FIELD_COUNT));
  assign acc_in     = vals_q[field_num_q];

  tcsv_acc u_acc (
    .acc_i   (acc_in),
    .digit_i (c[3:0]),
    .neg_i   (neg_q),
    .sum_o   (acc_sum)
  );

  // Emit controls
  logic emit, emit_cut;

  // Parse one byte against the frame state
  always_comb begin
    in_frame_d  = in_frame_q;
    field_num_d = field_num_q;
    frame_cnt_d = frame_cnt_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    wr_digit    = 1'b0;
    emit        = 1'b0;
    emit_cut    = 1'b0;

    if (!in_frame_q || is_hdr) begin
      // Hunting or closing header: a header opens a fresh frame
      emit = in_frame_q && is_hdr;
      if (is_hdr) begin
        in_frame_d  = 1'b1;
        field_num_d = '0;
        frame_cnt_d = 8'd1;
        phase_d     = PH_SKIP;
        neg_d       = 1'b0;
      end
    end else begin
      if (is_sep) begin
        if (phase_q != PH_PAST && !last_field) begin
          field_num_d = field_num_q + FN_W'(1);
          phase_d     = PH_SKIP;
          neg_d       = 1'b0;
        end else begin
          phase_d = PH_PAST;
        end
      end else if (phase_q == PH_END || phase_q == PH_PAST) begin
        phase_d = phase_q;
      end else if (is_digit) begin
        wr_digit = 1'b1;
        phase_d  = PH_NUM;
      end else if (phase_q == PH_SKIP && is_blank) begin
        phase_d = PH_SKIP;
      end else if (phase_q == PH_SKIP && is_sign) begin
        neg_d   = (c == CH_MINUS);
        phase_d = PH_NUM;
      end else begin
        phase_d = PH_END;
      end

      // Count the byte and force out the frame at the window length
      if (cnt_inc >= window_eff) begin
        emit        = 1'b1;
        emit_cut    = 1'b1;
        in_frame_d  = 1'b0;
        frame_cnt_d = 8'd0;
      end else begin
        frame_cnt_d = cnt_inc;
      end
    end
  end

  // Field value update: digit write, then clear on a frame open
  always_comb begin
    for (int k = 0; k < FIELD_COUNT; k++) begin
      vals_take[k] = (wr_digit && (field_num_q == FN_W'(k))) ? acc_sum : vals_q[k];
      vals_d[k]    = is_hdr ? value_t'(0) : vals_take[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      field_num_q <= '0;
      frame_cnt_q <= 8'd0;
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        vals_q[k] <= '0;
      end
    end else if (adv) begin
      in_frame_q  <= in_frame_d;
      field_num_q <= field_num_d;
      frame_cnt_q <= frame_cnt_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        vals_q[k] <= vals_d[k];
      end
    end
  end

  // Result register
  logic   out_valid_q, out_valid_d;
  logic   out_cut_q;
  value_t out_vals_q [FIELD_COUNT];

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the values seen before a closing header, or after the window byte
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_cut_q <= emit_cut;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        out_vals_q[k] <= emit_cut ? vals_take[k] : vals_q[k];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_cut_q;

  for (genvar k = 0; k < OUT_VALUES; k++) begin : g_lane
    if (k < FIELD_COUNT) begin : g_val
      assign m_axis_tdata[k*VALUE_BITS +: VALUE_BITS] = out_vals_q[k];
    end else begin : g_zero
      assign m_axis_tdata[k*VALUE_BITS +: VALUE_BITS] = '0;
    end
  end

`ifndef SYNTH
  a_window_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit && emit_cut) |=> (!in_frame_q && m_axis_tvalid && m_axis_tuser))
    else $error("window emit did not return to hunting");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (field_num_q < FN_W'(FIELD_COUNT)))
    else $error("field number out of range");

  a_hunt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (frame_cnt_q == 8'd0))
    else $error("byte count not cleared while hunting");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked frame");

  a_header_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_hdr) |=> (in_frame_q && frame_cnt_q == 8'd1))
    else $error("header did not open a frame");
`endif

endmodule : telemetry_csv_field_parser_unit

`default_nettype wire

// ===== rtl/core/tcsv_acc.sv =====
// Saturating decimal digit accumulator: value * 10 +/- digit, clamped to the value range.
`default_nettype none

module tcsv_acc
  import tcsv_pkg::*;
(
  input  value_t     acc_i,
  input  logic [3:0] digit_i,
  input  logic       neg_i,
  output value_t     sum_o
);

  localparam int W = VALUE_BITS + 5;
  localparam logic signed [W-1:0] HI = W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [W-1:0] LO = W'(-(64'sd1 <<< (VALUE_BITS - 1)));

  logic signed [W-1:0] wide;
  logic signed [W-1:0] times10;
  logic signed [W-1:0] dig;
  logic signed [W-1:0] sum;

  // Scale by ten with two shifts, then add or subtract the digit
  always_comb begin
    wide    = W'(acc_i);
    dig     = W'($signed({1'b0, digit_i}));
    times10 = (wide <<< 3) + (wide <<< 1);
    sum     = neg_i ? (times10 - dig) : (times10 + dig);
    if (sum > HI) begin
      sum_o = value_t'(HI);
    end else if (sum < LO) begin
      sum_o = value_t'(LO);
    end else begin
      sum_o = value_t'(sum);
    end
  end

endmodule : tcsv_acc

`default_nettype wire
